FILE: src/mp2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_pkg: shared definitions for the 2x2 mean pooling unit
// Field widths, configuration register indexes and reset values used by the
// pooling datapath and its port checker.
// ----------------------------------------------------------------------------
package mp2_pkg;

  // Pixel and pooled value width.
  localparam int DATA_W = 32;
  // Horizontal pair sum width, one bit of growth over a pixel.
  localparam int PAIR_W = DATA_W + 1;

  // Configuration register widths.
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Row counter covers frames of up to HEIGHT_LIMIT rows.
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = 12;

  // Defaults.
  localparam int DEFAULT_MAX_WIDTH = 1024;
  localparam int RESET_WIDTH       = 1024;
  localparam int RESET_HEIGHT      = 1024;

endpackage

FILE: src/mean_pool_2x2_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mean_pool_2x2_unit: 2x2 stride-2 average pooling on a raster pixel stream
// Path: once its bottom-right pixel is accepted, a window's result passes the
//   line store read register, then the output register, to the master side.
// Throughput: one pixel per cycle while the output is not back-pressured; only
//   window-closing pixels reach the final add and the constant shift.
// Reset: rst is synchronous and active high; it clears the counters, the
//   pipeline valids and the left pixel, and loads width and height of 1024.
//   The line store is not cleared; it is filled by every even row.
// ----------------------------------------------------------------------------
module mean_pool_2x2_unit #(
  parameter int MAX_WIDTH = mp2_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // Slave side: tdata = pixel[31:0].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mp2_pkg::DATA_W-1:0]       s_tdata,
  // Master side: tdata = pooled[31:0]; tlast = frame_last.
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [mp2_pkg::DATA_W-1:0]       m_tdata,
  output logic                             m_tlast,
  // Configuration write port.
  input  logic                             cfg_wr_en,
  input  logic [mp2_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
  import mp2_pkg::*;

  // Column counter must hold MAX_WIDTH-1 and leave at least one bit for the
  // pair index after the column parity bit is dropped.
  localparam int COL_W      = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) : 2;
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  // Width used while clamping a written width value.
  localparam int WCL_W      = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
                              $clog2(MAX_WIDTH + 1) : WIDTH_REG_W;
  localparam int RST_W_EFF  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
  localparam int RST_H_EFF  = (RESET_HEIGHT > HEIGHT_LIMIT) ? HEIGHT_LIMIT : RESET_HEIGHT;

  // Frame geometry, held in the form the counters compare against. The
  // clamping to the legal range is done once, when the register is written.
  logic [COL_W-1:0] col_last;     // effective width - 1
  logic [COL_W-1:0] col_pairs;    // complete column pairs per row
  logic [COL_W-1:0] col_final;    // column of the last pooled window
  logic [ROW_W-1:0] row_last;     // effective height - 1
  logic [ROW_W-1:0] row_pairs;    // complete row pairs per frame
  logic [ROW_W-1:0] row_final;    // row of the last pooled window

  logic [WCL_W-1:0]        wr_width_raw;
  logic [WCL_W-1:0]        wr_width_eff;
  logic [HEIGHT_REG_W-1:0] wr_height_raw;
  logic [HEIGHT_REG_W-1:0] wr_height_eff;

  always_comb begin
    wr_width_raw = WCL_W'(cfg_wr_data[WIDTH_REG_W-1:0]);
    if (wr_width_raw < WCL_W'(2)) begin
      wr_width_eff = WCL_W'(2);
    end else if (wr_width_raw > WCL_W'(MAX_WIDTH)) begin
      wr_width_eff = WCL_W'(MAX_WIDTH);
    end else begin
      wr_width_eff = wr_width_raw;
    end

    wr_height_raw = cfg_wr_data[HEIGHT_REG_W-1:0];
    if (wr_height_raw < HEIGHT_REG_W'(2)) begin
      wr_height_eff = HEIGHT_REG_W'(2);
    end else if (wr_height_raw > HEIGHT_REG_W'(HEIGHT_LIMIT)) begin
      wr_height_eff = HEIGHT_REG_W'(HEIGHT_LIMIT);
    end else begin
      wr_height_eff = wr_height_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= COL_W'(RST_W_EFF - 1);
      col_pairs <= COL_W'(RST_W_EFF / 2);
      col_final <= COL_W'((RST_W_EFF / 2) * 2 - 1);
      row_last  <= ROW_W'(RST_H_EFF - 1);
      row_pairs <= ROW_W'(RST_H_EFF / 2);
      row_final <= ROW_W'((RST_H_EFF / 2) * 2 - 1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          col_last  <= COL_W'(wr_width_eff - WCL_W'(1));
          col_pairs <= COL_W'(wr_width_eff >> 1);
          col_final <= COL_W'({wr_width_eff[WCL_W-1:1], 1'b0} - WCL_W'(1));
        end
        REG_IMAGE_HEIGHT: begin
          row_last  <= ROW_W'(wr_height_eff - HEIGHT_REG_W'(1));
          row_pairs <= ROW_W'(wr_height_eff >> 1);
          row_final <= ROW_W'({wr_height_eff[HEIGHT_REG_W-1:1], 1'b0}
                              - HEIGHT_REG_W'(1));
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake. Only pixels that close a window enter the result pipeline;
  // every other pixel is finished in the cycle it is accepted. The result
  // stage advances whenever the output register is empty or being drained.
  logic s1_valid;
  logic s1_move;
  logic accept;

  assign s1_move  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  // Position decode for the pixel now on the input.
  logic [COL_W-1:0]   col_count;
  logic [ROW_W-1:0]   row_count;
  logic [COL_W-2:0]   pair;
  logic               pair_in_range;
  logic               row_pair_in_range;
  logic               store_pair;
  logic               close_window;
  logic               window_last;
  logic [PAIR_W-1:0]  hsum;
  logic [DATA_W-1:0]  left_pixel;

  assign pair              = col_count[COL_W-1:1];
  assign pair_in_range     = {1'b0, pair} < col_pairs;
  assign row_pair_in_range = {1'b0, row_count[ROW_W-1:1]} < row_pairs;
  assign store_pair        = col_count[0] && pair_in_range && !row_count[0];
  assign close_window      = col_count[0] && pair_in_range && row_count[0] &&
                             row_pair_in_range;
  assign window_last       = (col_count == col_final) && (row_count == row_final);
  assign hsum              = {left_pixel[DATA_W-1], left_pixel} +
                             {s_tdata[DATA_W-1], s_tdata};

  // Raster counters. A counter at or past its last position wraps, which
  // also keeps the stream aligned after a geometry change.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      left_pixel <= '0;
    end else if (accept) begin
      if (!col_count[0]) begin
        left_pixel <= s_tdata;
      end
      if (col_count >= col_last) begin
        col_count <= '0;
        row_count <= (row_count >= row_last) ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // Line store of horizontal pair sums from the even row. An odd row reads
  // the entry above it in the same cycle its own pair sum is formed; the
  // write for that entry always lies at least one row earlier.
  logic [PAIR_W-1:0] line_mem [LINE_DEPTH];
  logic [PAIR_W-1:0] upper_pair;

  always_ff @(posedge clk) begin
    if (accept && store_pair) begin
      line_mem[pair[LINE_AW-1:0]] <= hsum;
    end
    if (accept && close_window) begin
      upper_pair <= line_mem[pair[LINE_AW-1:0]];
    end
  end

  // Result stage: holds the lower pair sum beside the upper one read from the line store.
  logic [PAIR_W-1:0] s1_hsum;
  logic              s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= close_window;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && close_window) begin
      s1_hsum <= hsum;
      s1_last <= window_last;
    end
  end

  // Window sum divided by four, rounded toward zero: negative sums get a
  // bias of three before the arithmetic shift.
  logic [PAIR_W:0]   window_sum;
  logic [PAIR_W:0]   biased_sum;
  logic [DATA_W-1:0] pooled_next;

  assign window_sum  = {upper_pair[PAIR_W-1], upper_pair} +
                       {s1_hsum[PAIR_W-1], s1_hsum};
  assign biased_sum  = window_sum + (window_sum[PAIR_W] ? (PAIR_W + 1)'(3) : '0);
  assign pooled_next = biased_sum[DATA_W+1:2];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_tdata <= pooled_next;
      m_tlast <= s1_last;
    end
  end

endmodule

FILE: src/mp2_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mp2_port_checker: port-level checks for the 2x2 mean pooling unit
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module mp2_port_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [mp2_pkg::DATA_W-1:0] m_tdata,
  input logic                       m_tlast
);
  import mp2_pkg::*;

  // Reset empties the output register.
  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A result held by backpressure keeps its payload.
  a_stalled_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // A fresh result traces back to an accepted pixel through the result stage and output register.
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a matching input transaction");

  // With the output register free to drain, the input never stalls.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid || m_tready) |-> s_tready)
    else $error("input stalled while output can drain");

endmodule

bind mean_pool_2x2_unit mp2_port_checker u_mp2_port_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
